// ----- sv/fxg_pkg.sv -----
// Shared types, widths, action codes and status codes of the XOR group FEC decoder.
package fxg_pkg;

    localparam int PAYLOAD_BYTES_DEF = 1024;
    localparam int MAX_GROUP_DEF     = 63;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 9;
    localparam int SEQ_W    = 16;
    localparam int SIZE_W   = 6;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 3;
    // one quotient bit per step of each restoring divider
    localparam int DIV_STEPS = SEQ_W;

    localparam logic [STATUS_W-1:0] ST_SHORT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DATA        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RECOVERED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PARITY_DROP = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAIL        = 3'd4;

    typedef enum logic [2:0] {
        ACT_PASS      = 3'd0,
        ACT_LOAD      = 3'd1,
        ACT_XOR       = 3'd2,
        ACT_DUP       = 3'd3,
        ACT_RECOVER   = 3'd4,
        ACT_LOAD_DROP = 3'd5,
        ACT_DROP      = 3'd6,
        ACT_FAIL      = 3'd7
    } t_act;

    typedef struct packed {
        logic [WORD_W-1:0]  word_data;
        logic [INDEX_W-1:0] word_index;
        logic               last_word;
        logic               full_frame;
        logic [SEQ_W-1:0]   group_seq;
        logic [SIZE_W-1:0]  group_size;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0]   out_word;
        logic [INDEX_W-1:0]  out_index;
        logic                out_last;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    function automatic logic [STATUS_W-1:0] act_status(input t_act act);
        logic [STATUS_W-1:0] st;
        case (act)
            ACT_PASS:      st = ST_SHORT;
            ACT_LOAD:      st = ST_DATA;
            ACT_XOR:       st = ST_DATA;
            ACT_DUP:       st = ST_DATA;
            ACT_RECOVER:   st = ST_RECOVERED;
            ACT_LOAD_DROP: st = ST_PARITY_DROP;
            ACT_DROP:      st = ST_PARITY_DROP;
            ACT_FAIL:      st = ST_FAIL;
            default:       st = ST_SHORT;
        endcase
        return st;
    endfunction

endpackage

// ----- sv/fxg_div.sv -----
// Iterative restoring divider: sequence number by group size, one quotient bit per cycle.
module fxg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fxg_pkg::SEQ_W-1:0]  i_dividend,
    input  logic [fxg_pkg::SIZE_W-1:0] i_divisor,
    output logic [fxg_pkg::SEQ_W-1:0]  o_quotient,
    output logic [fxg_pkg::SIZE_W-1:0] o_remainder,
    output logic                       o_done
);
    import fxg_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SIZE_W-1:0]  r_rem, n_rem;
    logic [SEQ_W-1:0]   r_quo, n_quo;
    logic [SIZE_W-1:0]  r_dvs, n_dvs;
    logic [SIZE_W:0]    w_trial;
    logic [SIZE_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[SEQ_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // shift the dividend out at the top, the quotient bit in at the bottom
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_diff[SIZE_W-1:0];
                n_quo = {r_quo[SEQ_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[SIZE_W-1:0];
                n_quo = {r_quo[SEQ_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

// ----- sv/fxg_buf.sv -----
// XOR accumulation buffer: one write port, one registered read port.
module fxg_buf #(
    parameter int DEPTH = fxg_pkg::PAYLOAD_BYTES_DEF / 4 + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [fxg_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [fxg_pkg::WORD_W-1:0] o_rd_data
);
    import fxg_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/fec_xor_group_decoder.sv -----
// Receive-side XOR parity FEC decoder: verdict per frame, XOR buffer, recovery of one member.
//
// Input channel i_in_valid / o_in_ready carries one frame word per transfer (i_in_word).
// Output channel o_out_valid / i_out_ready returns exactly one word per input word, in order.
// The word at index 0 decides the action for its whole frame; later words follow that verdict.
// Timing: a body word is taken and its buffer entry is read at the same edge; the result is
// registered in S_EX once the output register is free. A header word of a full frame
// with a valid group size also runs the 16-step restoring dividers (sequence number and last
// sequence number by group size) in S_DIV before S_EX registers its result; the next word
// is taken back in S_IDLE. Header words of short frames skip the dividers like body words.
// Buffer read-modify-write is serialized: a write lands before the next read is issued.
// After reset all PAYLOAD_BYTES/4+1 buffer entries (257 by default) are cleared with
// o_in_ready low; group state and verdict return to zero (short pass).
// When the receiver stalls, the finished word waits in the output register and the block
// waits with the next result until the register is free; new words are still taken once
// the current one has moved into the output register.
module fec_xor_group_decoder #(
    parameter int PAYLOAD_BYTES = fxg_pkg::PAYLOAD_BYTES_DEF,
    parameter int MAX_GROUP     = fxg_pkg::MAX_GROUP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fxg_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fxg_pkg::t_out_word o_out_word
);
    import fxg_pkg::*;

    localparam int BUF_WORDS = PAYLOAD_BYTES / 4 + 1;
    localparam int AW        = $clog2(BUF_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIV   = 4'b0100,
        S_EX    = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    t_act                   r_verdict, n_verdict;
    logic [SEQ_W-1:0]       r_last_seq, n_last_seq;
    logic [MAX_GROUP-1:0]   r_mask, n_mask;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic                   r_out_valid, n_out_valid;
    t_in_word               r_in;
    t_out_word              r_out;

    logic                   w_in_acc;
    logic                   w_hdr_ok;
    logic                   w_div_start;
    logic [SEQ_W-1:0]       w_q_seq;
    logic [SEQ_W-1:0]       w_q_last;
    logic [SIZE_W-1:0]      w_pos;
    logic                   w_done_seq;
    logic                   w_done_last;
    logic [MAX_GROUP-1:0]   w_bit;
    logic [SIZE_W-1:0]      w_parity_pos;
    logic                   w_in_buf;
    logic                   w_out_free;
    logic                   w_out_load;
    logic [WORD_W-1:0]      w_rd_data;
    logic [WORD_W-1:0]      w_result;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [WORD_W-1:0]      w_wr_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_hdr_ok    = i_in_word.full_frame && (i_in_word.group_size >= SIZE_W'(3))
                         && (32'(i_in_word.group_size) <= MAX_GROUP);
    assign w_div_start = w_in_acc && (i_in_word.word_index == '0) && w_hdr_ok;

    fxg_div u_div_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (i_in_word.group_seq),
        .i_divisor   (i_in_word.group_size),
        .o_quotient  (w_q_seq),
        .o_remainder (w_pos),
        .o_done      (w_done_seq)
    );

    fxg_div u_div_last (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_last_seq),
        .i_divisor   (i_in_word.group_size),
        .o_quotient  (w_q_last),
        .o_remainder (),
        .o_done      (w_done_last)
    );

    fxg_buf #(
        .DEPTH (BUF_WORDS),
        .AW    (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (AW'(i_in_word.word_index)),
        .o_rd_data (w_rd_data)
    );

    assign w_bit        = MAX_GROUP'(1) << w_pos;
    assign w_parity_pos = r_in.group_size - SIZE_W'(1);
    assign w_in_buf     = (32'(r_in.word_index) < BUF_WORDS);
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_out_load   = (r_state == S_EX) && w_out_free;

    // result word of the current item
    always_comb begin
        w_result = r_in.word_data;
        if (w_in_buf && (r_verdict == ACT_RECOVER)) begin
            w_result = r_in.word_data ^ w_rd_data;
            if (r_in.word_index == '0) begin
                // keep the parity frame's own type byte
                w_result[7:0] = r_in.word_data[7:0];
            end
        end
    end

    // buffer write: clearing sweep, or load / accumulate of the current word
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = AW'(r_in.word_index);
        w_wr_data = r_in.word_data;
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else if (w_out_load && w_in_buf) begin
            case (r_verdict)
                ACT_LOAD, ACT_LOAD_DROP: begin
                    w_wr_en = 1'b1;
                end
                ACT_XOR: begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_in.word_data ^ w_rd_data;
                end
                default: begin
                    w_wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_verdict   = r_verdict;
        n_last_seq  = r_last_seq;
        n_mask      = r_mask;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(BUF_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_div_start) begin
                        n_state = S_DIV;
                    end else begin
                        if (i_in_word.word_index == '0) begin
                            n_verdict = ACT_PASS;
                        end
                        n_state = S_EX;
                    end
                end
            end
            S_DIV: begin
                if (w_done_seq) begin
                    n_last_seq = r_in.group_seq;
                    n_state    = S_EX;
                    if (w_q_seq != w_q_last) begin
                        // first frame of a new group opens the buffer
                        n_mask    = w_bit;
                        n_count   = COUNT_W'(1);
                        n_verdict = (w_pos != w_parity_pos) ? ACT_LOAD : ACT_LOAD_DROP;
                    end else if (w_pos == w_parity_pos) begin
                        if (r_count == COUNT_W'(w_parity_pos)) begin
                            n_verdict = ACT_DROP;
                        end else if (r_count != COUNT_W'(r_in.group_size - SIZE_W'(2))) begin
                            n_verdict = ACT_FAIL;
                        end else begin
                            n_verdict = ACT_RECOVER;
                        end
                    end else if ((r_mask & w_bit) == '0) begin
                        n_mask    = r_mask | w_bit;
                        n_count   = r_count + COUNT_W'(1);
                        n_verdict = ACT_XOR;
                    end else begin
                        n_verdict = ACT_DUP;
                    end
                end
            end
            S_EX: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_verdict   <= ACT_PASS;
            r_last_seq  <= '0;
            r_mask      <= '0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_verdict   <= n_verdict;
            r_last_seq  <= n_last_seq;
            r_mask      <= n_mask;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_word;
        end
        if (w_out_load) begin
            r_out.out_word  <= w_result;
            r_out.out_index <= r_in.word_index;
            r_out.out_last  <= r_in.last_word;
            r_out.status    <= act_status(r_verdict);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_mask))
        else $error("seen count differs from number of seen members");

    a_dividers_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_seq == w_done_last)
        else $error("dividers finished on different cycles");

    a_accept_next_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV) || (r_state == S_EX))
        else $error("accepted word did not move to divide or execute");

    a_no_write_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) || (r_state == S_IDLE) |-> !w_wr_en)
        else $error("buffer written outside clear or execute");

    a_out_follows_execute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) && w_out_free |=> o_out_valid && (r_state == S_IDLE))
        else $error("finished word not presented on the output");

endmodule
